>>> hdl/vfms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfms_pkg
// Shared widths, the status type and the sequencer states of the vector field
// magnitude statistics block.
// ----------------------------------------------------------------------------
package vfms_pkg;

   localparam int DEFAULT_MAX_PIXELS = 4096;

   localparam int VEL_W     = 16;
   localparam int MAG_W     = 16;
   localparam int TOTAL_W   = 28;
   localparam int DIR_W     = 16;
   localparam int CFG_W     = 13;
   localparam int SUM_W     = 29;
   localparam int CFG_RESET = 4096;

   localparam int MUL_W  = 17;
   localparam int PROD_W = 34;

   localparam int SQ_IN_W  = 64;
   localparam int SQ_OUT_W = 32;
   localparam int SQ_REM_W = 36;

   localparam int DIV_N_W = 64;
   localparam int DIV_D_W = 32;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ,
      ST_MAG_START,
      ST_MAG_WAIT,
      ST_ACC,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_VAR,
      ST_VDIV_START,
      ST_VDIV_WAIT,
      ST_STD_START,
      ST_STD_WAIT,
      ST_S2,
      ST_NORM,
      ST_LEN_START,
      ST_LEN_WAIT,
      ST_DIR_START,
      ST_DIR_WAIT,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

>>> hdl/vfms_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfms_mem
// Magnitude store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vfms_mem #(
   parameter int DEPTH = vfms_pkg::DEFAULT_MAX_PIXELS,
   parameter int AW    = 12
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [vfms_pkg::MAG_W-1:0] wr_data,
   input  wire logic [AW-1:0]             rd_addr,
   output logic      [vfms_pkg::MAG_W-1:0] rd_data
);
   import vfms_pkg::*;

   logic [MAG_W-1:0] store_ff [DEPTH];
   logic [MAG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/vfms_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfms_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module vfms_mul (
   input  wire logic                       clock,
   input  wire logic [vfms_pkg::MUL_W-1:0]  op_a,
   input  wire logic [vfms_pkg::MUL_W-1:0]  op_b,
   output logic      [vfms_pkg::PROD_W-1:0] product
);
   import vfms_pkg::*;

   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

   assign product = prod_ff;

endmodule
`default_nettype wire

>>> hdl/vfms_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfms_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module vfms_sqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [vfms_pkg::SQ_IN_W-1:0]  value,
   output logic      [vfms_pkg::SQ_OUT_W-1:0] root,
   output vfms_pkg::unit_status_type         status
);
   import vfms_pkg::*;

   localparam int CNT_W = $clog2(SQ_OUT_W + 1);

   logic [SQ_IN_W-1:0]  val_ff, val_in;
   logic [SQ_REM_W-1:0] rem_ff, rem_in;
   logic [SQ_OUT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SQ_REM_W-1:0] rem_sh;
   logic [SQ_REM_W-1:0] trial;

   always_comb begin
      rem_sh  = {rem_ff[SQ_REM_W-3:0], val_ff[SQ_IN_W-1 -: 2]};
      trial   = {{(SQ_REM_W-SQ_OUT_W-2){1'b0}}, root_ff, 2'b01};
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(SQ_OUT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = val_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[SQ_OUT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[SQ_OUT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root   = root_ff;
   assign status = '{busy: busy_ff, done: done_ff};

endmodule
`default_nettype wire

>>> hdl/vfms_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfms_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vfms_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [vfms_pkg::DIV_N_W-1:0] dividend,
   input  wire logic [vfms_pkg::DIV_D_W-1:0] divisor,
   output logic      [vfms_pkg::DIV_N_W-1:0] quotient,
   output vfms_pkg::unit_status_type        status
);
   import vfms_pkg::*;

   localparam int CNT_W = $clog2(DIV_N_W + 1);

   logic [DIV_N_W-1:0] dd_ff, dd_in;
   logic [DIV_D_W-1:0] r_ff, r_in;
   logic [DIV_D_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_D_W:0]   r_sh;
   logic [DIV_D_W:0]   diff;
   logic               ge;

   always_comb begin
      r_sh    = {r_ff, dd_ff[DIV_N_W-1]};
      diff    = r_sh - {1'b0, d_ff};
      ge      = (r_sh >= {1'b0, d_ff});
      dd_in   = dd_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dd_in   = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = CNT_W'(DIV_N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = ge ? diff[DIV_D_W-1:0] : r_sh[DIV_D_W-1:0];
         dd_in  = {dd_ff[DIV_N_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dd_ff <= dd_in;
      r_ff  <= r_in;
      d_ff  <= d_in;
   end

   assign quotient = dd_ff;
   assign status   = '{busy: busy_ff, done: done_ff};

endmodule
`default_nettype wire

>>> hdl/vector_field_magnitude_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vector_field_magnitude_stats
// Per-frame mean, standard deviation, total magnitude and direction of a 4-component field.
// ----------------------------------------------------------------------------
// One pixel item is taken at a time: four squares on the shared multiplier,
// a 32-step square root at two bits per cycle, then a write to the
// magnitude store and an update of the sums. The pixel that closes a frame
// adds the mean division, a pass over the N stored magnitudes at one per
// cycle, the variance division and root, twelve partial products for the
// squared sum length, up to 30 normalizing steps, one more root and four
// direction divisions. The result sits in an output register, so the next
// frame can begin while it waits. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module vector_field_magnitude_stats #(
   parameter int MAX_PIXELS = vfms_pkg::DEFAULT_MAX_PIXELS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [vfms_pkg::VEL_W-1:0]  req_vel_x,
   input  wire logic signed [vfms_pkg::VEL_W-1:0]  req_vel_y,
   input  wire logic signed [vfms_pkg::VEL_W-1:0]  req_vel_z,
   input  wire logic signed [vfms_pkg::VEL_W-1:0]  req_vel_w,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic        [vfms_pkg::MAG_W-1:0]       rsp_mean_magnitude,
   output logic        [vfms_pkg::MAG_W-1:0]       rsp_stdev_magnitude,
   output logic        [vfms_pkg::TOTAL_W-1:0]     rsp_total_magnitude,
   output logic signed [vfms_pkg::DIR_W-1:0]       rsp_dir_x,
   output logic signed [vfms_pkg::DIR_W-1:0]       rsp_dir_y,
   output logic signed [vfms_pkg::DIR_W-1:0]       rsp_dir_z,
   output logic signed [vfms_pkg::DIR_W-1:0]       rsp_dir_w,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic        [vfms_pkg::CFG_W-1:0]  csr_data
);
   import vfms_pkg::*;

   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CW = $clog2(MAX_PIXELS + 1);
   localparam int QW = 32 + CW;

   function automatic logic [MUL_W-1:0] abs_vel(input logic signed [VEL_W-1:0] v);
      logic [MUL_W-1:0] e;
      e = {v[VEL_W-1], v};
      abs_vel = v[VEL_W-1] ? (~e + MUL_W'(1)) : e;
   endfunction

   function automatic logic [SUM_W-1:0] abs_sum(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] e;
      e = v;
      abs_sum = v[SUM_W-1] ? (~e + SUM_W'(1)) : e;
   endfunction

   state_type state_ff, state_in;

   logic [CFG_W-1:0]        cfg_ff, cfg_in;
   logic signed [VEL_W-1:0] vel_ff [4];
   logic signed [VEL_W-1:0] vel_in [4];
   logic signed [SUM_W-1:0] sum_ff [4];
   logic signed [SUM_W-1:0] sum_in [4];
   logic [TOTAL_W-1:0]      msum_ff, msum_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           n_ff, n_in;
   logic [3:0]              step_ff, step_in;
   logic [1:0]              comp_ff, comp_in;
   logic [1:0]              part_ff, part_in;
   logic [1:0]              tag_ff, tag_in;
   logic                    tv_ff, tv_in;
   logic [32:0]             sq_ff, sq_in;
   logic [MAG_W-1:0]        mean_ff, mean_in;
   logic [MAG_W-1:0]        stdev_ff, stdev_in;
   logic [QW-1:0]           qsum_ff, qsum_in;
   logic [63:0]             s2_ff, s2_in;
   logic [4:0]              shift_ff, shift_in;
   logic [SQ_OUT_W-1:0]     len_ff, len_in;
   logic [DIR_W-1:0]        dir_ff [4];
   logic [DIR_W-1:0]        dir_in [4];
   logic [CW-1:0]           vcnt_ff, vcnt_in;
   logic                    v_rd_ff, v_rd_in;
   logic                    v_mul_ff, v_mul_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0]        out_mean_ff, out_mean_in;
   logic [MAG_W-1:0]        out_stdev_ff, out_stdev_in;
   logic [TOTAL_W-1:0]      out_total_ff, out_total_in;
   logic [DIR_W-1:0]        out_dir_ff [4];
   logic [DIR_W-1:0]        out_dir_in [4];

   logic [MUL_W-1:0]        mul_a, mul_b;
   logic [PROD_W-1:0]       mul_p;
   logic                    sqrt_start;
   logic [SQ_IN_W-1:0]      sqrt_value;
   logic [SQ_OUT_W-1:0]     sqrt_root;
   unit_status_type         sqrt_st;
   logic                    div_start;
   logic [DIV_N_W-1:0]      div_num;
   logic [DIV_D_W-1:0]      div_den;
   logic [DIV_N_W-1:0]      div_quot;
   unit_status_type         div_st;
   logic                    mem_we;
   logic [AW-1:0]           mem_raddr;
   logic [MAG_W-1:0]        mem_wdata;
   logic [MAG_W-1:0]        mem_rdata;

   logic [CW-1:0]           count_eff;
   logic [CW-1:0]           n_w;
   logic [MAG_W-1:0]        absd;
   logic [SUM_W-1:0]        a_sum;
   logic [29:0]             sum_t;
   logic [TOTAL_W:0]        msum_t;
   logic [15:0]             qclamp;
   logic [5:0]              shamt;

   vfms_mem #(.DEPTH(MAX_PIXELS), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (idx_ff),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   vfms_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   vfms_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sqrt_start),
      .value  (sqrt_value),
      .root   (sqrt_root),
      .status (sqrt_st)
   );

   vfms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_quot),
      .status   (div_st)
   );

   always_comb begin
      if (cfg_ff == '0) begin
         count_eff = CW'(1);
      end else if (32'(cfg_ff) > 32'(MAX_PIXELS)) begin
         count_eff = CW'(MAX_PIXELS);
      end else begin
         count_eff = CW'(cfg_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cfg_in       = csr_valid ? csr_data : cfg_ff;
      msum_in      = msum_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      step_in      = step_ff;
      comp_in      = comp_ff;
      part_in      = part_ff;
      tag_in       = part_ff;
      tv_in        = 1'b0;
      sq_in        = sq_ff;
      mean_in      = mean_ff;
      stdev_in     = stdev_ff;
      qsum_in      = qsum_ff;
      s2_in        = s2_ff;
      shift_in     = shift_ff;
      len_in       = len_ff;
      vcnt_in      = vcnt_ff;
      v_rd_in      = 1'b0;
      v_mul_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_mean_in  = out_mean_ff;
      out_stdev_in = out_stdev_ff;
      out_total_in = out_total_ff;
      for (int k = 0; k < 4; k++) begin
         vel_in[k]     = vel_ff[k];
         sum_in[k]     = sum_ff[k];
         dir_in[k]     = dir_ff[k];
         out_dir_in[k] = out_dir_ff[k];
      end
      mul_a      = '0;
      mul_b      = '0;
      sqrt_start = 1'b0;
      sqrt_value = '0;
      div_start  = 1'b0;
      div_num    = '0;
      div_den    = '0;
      mem_we     = 1'b0;
      mem_raddr  = vcnt_ff[AW-1:0];
      mem_wdata  = (sqrt_root[SQ_OUT_W-1:MAG_W] != '0) ? '1 : sqrt_root[MAG_W-1:0];
      n_w        = CW'(idx_ff) + CW'(1);
      absd       = (mem_rdata >= mean_ff) ? (mem_rdata - mean_ff) : (mean_ff - mem_rdata);
      a_sum      = abs_sum(sum_ff[comp_ff]);
      sum_t      = '0;
      msum_t     = '0;
      qclamp     = (div_quot > 64'd16384) ? 16'd16384 : div_quot[15:0];
      shamt      = 6'(shift_ff) + 6'd14;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               vel_in[0] = req_vel_x;
               vel_in[1] = req_vel_y;
               vel_in[2] = req_vel_z;
               vel_in[3] = req_vel_w;
               sq_in     = '0;
               step_in   = '0;
               state_in  = ST_SQ;
            end
         end
         ST_SQ: begin
            // The product of the component fed in a cycle lands in the next.
            if (step_ff < 4'd4) begin
               mul_a = abs_vel(vel_ff[step_ff[1:0]]);
               mul_b = abs_vel(vel_ff[step_ff[1:0]]);
            end
            if (step_ff != 4'd0) begin
               sq_in = sq_ff + 33'(mul_p);
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd4) begin
               state_in = ST_MAG_START;
            end
         end
         ST_MAG_START: begin
            sqrt_start = 1'b1;
            sqrt_value = SQ_IN_W'(sq_ff);
            state_in   = ST_MAG_WAIT;
         end
         ST_MAG_WAIT: begin
            if (sqrt_st.done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            mem_we = 1'b1;
            for (int k = 0; k < 4; k++) begin
               sum_t = {sum_ff[k][SUM_W-1], sum_ff[k]} +
                       {{(30-VEL_W){vel_ff[k][VEL_W-1]}}, vel_ff[k]};
               if (sum_t[29] != sum_t[28]) begin
                  sum_in[k] = sum_t[29] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
               end else begin
                  sum_in[k] = sum_t[SUM_W-1:0];
               end
            end
            msum_t  = {1'b0, msum_ff} + (TOTAL_W+1)'(mem_wdata);
            msum_in = msum_t[TOTAL_W] ? '1 : msum_t[TOTAL_W-1:0];
            if (n_w < count_eff) begin
               idx_in   = AW'(n_w);
               state_in = ST_IDLE;
            end else begin
               n_in     = n_w;
               state_in = ST_MEAN_START;
            end
         end
         ST_MEAN_START: begin
            div_start = 1'b1;
            div_num   = DIV_N_W'(msum_ff) + DIV_N_W'(n_ff >> 1);
            div_den   = DIV_D_W'(n_ff);
            state_in  = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_st.done) begin
               mean_in  = (div_quot[DIV_N_W-1:MAG_W] != '0) ? '1 : div_quot[MAG_W-1:0];
               vcnt_in  = '0;
               qsum_in  = '0;
               state_in = ST_VAR;
            end
         end
         ST_VAR: begin
            // Read, square the deviation, accumulate: three items in flight.
            if (vcnt_ff < n_ff) begin
               vcnt_in = vcnt_ff + CW'(1);
               v_rd_in = 1'b1;
            end
            if (v_rd_ff) begin
               mul_a = MUL_W'(absd);
               mul_b = MUL_W'(absd);
            end
            v_mul_in = v_rd_ff;
            if (v_mul_ff) begin
               qsum_in = qsum_ff + QW'(mul_p);
            end
            if (vcnt_ff == n_ff && !v_rd_ff && !v_mul_ff) begin
               state_in = ST_VDIV_START;
            end
         end
         ST_VDIV_START: begin
            div_start = 1'b1;
            div_num   = DIV_N_W'(qsum_ff);
            div_den   = DIV_D_W'(n_ff);
            state_in  = ST_VDIV_WAIT;
         end
         ST_VDIV_WAIT: begin
            if (div_st.done) begin
               state_in = ST_STD_START;
            end
         end
         ST_STD_START: begin
            sqrt_start = 1'b1;
            sqrt_value = div_quot;
            state_in   = ST_STD_WAIT;
         end
         ST_STD_WAIT: begin
            if (sqrt_st.done) begin
               stdev_in = sqrt_root[MAG_W-1:0];
               step_in  = '0;
               comp_in  = '0;
               part_in  = '0;
               s2_in    = '0;
               state_in = ST_S2;
            end
         end
         ST_S2: begin
            // Each squared sum is built from three products of 15/14-bit halves.
            if (step_ff < 4'd12) begin
               case (part_ff)
                  2'd0: begin
                     mul_a = MUL_W'(a_sum[SUM_W-1:14]);
                     mul_b = MUL_W'(a_sum[SUM_W-1:14]);
                  end
                  2'd1: begin
                     mul_a = MUL_W'(a_sum[SUM_W-1:14]);
                     mul_b = MUL_W'(a_sum[13:0]);
                  end
                  default: begin
                     mul_a = MUL_W'(a_sum[13:0]);
                     mul_b = MUL_W'(a_sum[13:0]);
                  end
               endcase
               tv_in   = 1'b1;
               step_in = step_ff + 4'd1;
               if (part_ff == 2'd2) begin
                  part_in = '0;
                  comp_in = comp_ff + 2'd1;
               end else begin
                  part_in = part_ff + 2'd1;
               end
            end
            if (tv_ff) begin
               case (tag_ff)
                  2'd0:    s2_in = s2_ff + (64'(mul_p) << 28);
                  2'd1:    s2_in = s2_ff + (64'(mul_p) << 15);
                  default: s2_in = s2_ff + 64'(mul_p);
               endcase
            end
            if (step_ff == 4'd12 && !tv_ff) begin
               shift_in = '0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (s2_ff == '0) begin
               for (int k = 0; k < 4; k++) begin
                  dir_in[k] = '0;
               end
               state_in = ST_OUT;
            end else if (shift_ff < 5'd30 && s2_ff[63:60] == 4'd0) begin
               s2_in    = s2_ff << 2;
               shift_in = shift_ff + 5'd1;
            end else begin
               state_in = ST_LEN_START;
            end
         end
         ST_LEN_START: begin
            sqrt_start = 1'b1;
            sqrt_value = s2_ff;
            state_in   = ST_LEN_WAIT;
         end
         ST_LEN_WAIT: begin
            if (sqrt_st.done) begin
               len_in   = sqrt_root;
               comp_in  = '0;
               state_in = ST_DIR_START;
            end
         end
         ST_DIR_START: begin
            div_start = 1'b1;
            div_num   = (DIV_N_W'(a_sum) << shamt) + DIV_N_W'(len_ff >> 1);
            div_den   = len_ff;
            state_in  = ST_DIR_WAIT;
         end
         ST_DIR_WAIT: begin
            if (div_st.done) begin
               dir_in[comp_ff] = sum_ff[comp_ff][SUM_W-1] ? (~qclamp + 16'd1) : qclamp;
               if (comp_ff == 2'd3) begin
                  state_in = ST_OUT;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = ST_DIR_START;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_mean_in  = mean_ff;
               out_stdev_in = stdev_ff;
               out_total_in = msum_ff;
               for (int k = 0; k < 4; k++) begin
                  out_dir_in[k] = dir_ff[k];
                  sum_in[k]     = '0;
               end
               msum_in  = '0;
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= CFG_W'(CFG_RESET);
         msum_ff      <= '0;
         idx_ff       <= '0;
         step_ff      <= '0;
         comp_ff      <= '0;
         part_ff      <= '0;
         tv_ff        <= 1'b0;
         vcnt_ff      <= '0;
         v_rd_ff      <= 1'b0;
         v_mul_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            sum_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         msum_ff      <= msum_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         comp_ff      <= comp_in;
         part_ff      <= part_in;
         tv_ff        <= tv_in;
         vcnt_ff      <= vcnt_in;
         v_rd_ff      <= v_rd_in;
         v_mul_ff     <= v_mul_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < 4; k++) begin
            sum_ff[k] <= sum_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      tag_ff       <= tag_in;
      sq_ff        <= sq_in;
      mean_ff      <= mean_in;
      stdev_ff     <= stdev_in;
      qsum_ff      <= qsum_in;
      s2_ff        <= s2_in;
      shift_ff     <= shift_in;
      len_ff       <= len_in;
      out_mean_ff  <= out_mean_in;
      out_stdev_ff <= out_stdev_in;
      out_total_ff <= out_total_in;
      for (int k = 0; k < 4; k++) begin
         vel_ff[k]     <= vel_in[k];
         dir_ff[k]     <= dir_in[k];
         out_dir_ff[k] <= out_dir_in[k];
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mean_magnitude  = out_mean_ff;
   assign rsp_stdev_magnitude = out_stdev_ff;
   assign rsp_total_magnitude = out_total_ff;
   assign rsp_dir_x           = out_dir_ff[0];
   assign rsp_dir_y           = out_dir_ff[1];
   assign rsp_dir_z           = out_dir_ff[2];
   assign rsp_dir_w           = out_dir_ff[3];

`ifndef SYNTHESIS
   a_sqrt_free: assert property (@(posedge clock) disable iff (reset)
      sqrt_start |-> !sqrt_st.busy)
      else $error("square root started while busy");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_st.busy)
      else $error("divider started while busy");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output state");

   a_var_pipe: assert property (@(posedge clock) disable iff (reset)
      v_mul_ff |-> $past(v_rd_ff))
      else $error("variance product without a preceding store read");

   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == ST_OUT) && state_ff == ST_IDLE) |-> (idx_ff == '0 && msum_ff == '0))
      else $error("frame accumulators not cleared after a result");
`endif

endmodule
`default_nettype wire

>>> tb/tb_vector_field_magnitude_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_vector_field_magnitude_stats
// Self-checking bench for the frame statistics of a velocity field.
// ----------------------------------------------------------------------------
// A short table of directed items and pixel counts comes first, followed by
// random frames of mostly small size. Every accepted pixel goes through a
// local model of the frame statistics. Each frame result is compared field
// by field with the oldest pending expectation. Both sides of the item
// channel pause at random. Once, the result side holds off for a long time
// so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_vector_field_magnitude_stats;
   import vfms_pkg::*;

   localparam int NUM_PIXELS    = 4096;
   localparam int RANDOM_ITEMS  = 750;
   localparam int SETTLE_CYCLES = 120;
   localparam int LONG_HOLD     = 3000;
   localparam int CYCLE_LIMIT   = 4000000;

   typedef struct packed {
      logic [MAG_W-1:0]   mean;
      logic [MAG_W-1:0]   stdev;
      logic [TOTAL_W-1:0] total;
      logic [DIR_W-1:0]   dx;
      logic [DIR_W-1:0]   dy;
      logic [DIR_W-1:0]   dz;
      logic [DIR_W-1:0]   dw;
   } frame_stats_type;

   typedef enum logic {ROW_CONFIG, ROW_PIXEL} row_kind_type;

   // For config rows, vx holds the pixel count. Rows with typed set carry
   // their expected frame result in place.
   typedef struct packed {
      row_kind_type kind;
      int           vx, vy, vz, vw;
      bit           typed;
      int           mean, stdev, total, dx, dy, dz, dw;
   } stim_row_type;

   localparam int NUM_ROWS = 25;
   stim_row_type stim_rows [NUM_ROWS] = '{
      '{ROW_CONFIG, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, -32768, -32768, -32768, -32768, 1,
        65535, 0, 65535, -8192, -8192, -8192, -8192},
      '{ROW_PIXEL, 32767, 0, 0, 0, 1, 32767, 0, 32767, 16384, 0, 0, 0},
      '{ROW_PIXEL, 0, -32768, 0, 0, 1, 32768, 0, 32768, 0, -16384, 0, 0},
      '{ROW_PIXEL, 1, 1, 1, 1, 1, 2, 0, 2, 8192, 8192, 8192, 8192},
      '{ROW_PIXEL, 32767, 32767, 32767, 32767, 1,
        65534, 0, 65534, 8192, 8192, 8192, 8192},
      '{ROW_CONFIG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, 1234, -567, 89, -4321, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CONFIG, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, 100, 0, 0, -7, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, -100, 0, 0, 7, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CONFIG, 8191, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, 4096, -4096, 300, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, -20000, 123, 32767, -1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, 7, 7000, -7000, 70, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CONFIG, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, -1, 2, -3, 4, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CONFIG, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, 32767, -32768, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, -32768, 32767, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, 5, 5, -5, -5, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0}
   };

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [VEL_W-1:0]   req_vel_x, req_vel_y, req_vel_z, req_vel_w;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic        [MAG_W-1:0]   rsp_mean_magnitude;
   logic        [MAG_W-1:0]   rsp_stdev_magnitude;
   logic        [TOTAL_W-1:0] rsp_total_magnitude;
   logic signed [DIR_W-1:0]   rsp_dir_x, rsp_dir_y, rsp_dir_z, rsp_dir_w;
   logic                      csr_valid;
   logic                      csr_ready;
   logic        [CFG_W-1:0]   csr_data;

   vector_field_magnitude_stats DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_vel_x           (req_vel_x),
      .req_vel_y           (req_vel_y),
      .req_vel_z           (req_vel_z),
      .req_vel_w           (req_vel_w),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_mean_magnitude  (rsp_mean_magnitude),
      .rsp_stdev_magnitude (rsp_stdev_magnitude),
      .rsp_total_magnitude (rsp_total_magnitude),
      .rsp_dir_x           (rsp_dir_x),
      .rsp_dir_y           (rsp_dir_y),
      .rsp_dir_z           (rsp_dir_z),
      .rsp_dir_w           (rsp_dir_w),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   // Model state of the frame statistics.
   logic [MAG_W-1:0]   mag_history [NUM_PIXELS];
   longint             acc_x, acc_y, acc_z, acc_w;
   longint unsigned    acc_mag;
   int unsigned        frame_pos;
   int unsigned        frame_size_reg;

   frame_stats_type    pending_frames [$];
   int                 error_count  = 0;
   int                 cycle_count  = 0;
   bit                 hold_request = 1'b0;
   bit                 quiet        = 1'b0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bit_pos;
      root = 0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > v) bit_pos = bit_pos >> 2;
      while (bit_pos != 0) begin
         if (v >= root + bit_pos) begin
            v = v - (root + bit_pos);
            root = (root >> 1) + bit_pos;
         end else begin
            root = root >> 1;
         end
         bit_pos = bit_pos >> 2;
      end
      return root;
   endfunction

   function automatic longint clamp_sum(longint acc, longint v);
      longint r;
      r = acc + v;
      if (r > 64'sd268435455) return 64'sd268435455;
      if (r < -64'sd268435456) return -64'sd268435456;
      return r;
   endfunction

   function automatic longint unsigned magnitude_of(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // One component of the unit sum vector in Q1.14; len is the length
   // scaled up by 2^shift.
   function automatic logic [DIR_W-1:0] unit_component(longint c, longint unsigned len,
                                                       int shift);
      longint unsigned q;
      q = ((magnitude_of(c) << (14 + shift)) + len / 2) / len;
      if (q > 16384) q = 16384;
      if (c < 0) q = -q;
      return q[DIR_W-1:0];
   endfunction

   // Takes one pixel into the model and returns 1 when it closes a frame.
   function automatic bit take_pixel(logic signed [VEL_W-1:0] x, y, z, w,
                                     output frame_stats_type stats);
      longint          sx, sy, sz, sw;
      longint unsigned sq, mag, mean, qsum, s2, len;
      longint          d;
      int unsigned     count, n;
      int              shift;
      sx = x; sy = y; sz = z; sw = w;
      sq = sx * sx + sy * sy + sz * sz + sw * sw;
      mag = int_sqrt(sq);
      if (mag > 65535) mag = 65535;
      stats = '0;
      if (frame_pos >= NUM_PIXELS) frame_pos = 0;
      mag_history[frame_pos] = mag[MAG_W-1:0];
      acc_x = clamp_sum(acc_x, sx);
      acc_y = clamp_sum(acc_y, sy);
      acc_z = clamp_sum(acc_z, sz);
      acc_w = clamp_sum(acc_w, sw);
      acc_mag = acc_mag + mag;
      if (acc_mag > 268435455) acc_mag = 268435455;
      count = frame_size_reg;
      if (count == 0) count = 1;
      if (count > NUM_PIXELS) count = NUM_PIXELS;
      if (frame_pos + 1 < count) begin
         frame_pos++;
         return 0;
      end
      n = frame_pos + 1;
      mean = (acc_mag + n / 2) / n;
      if (mean > 65535) mean = 65535;
      qsum = 0;
      for (int i = 0; i < n; i++) begin
         d = longint'(mag_history[i]) - longint'(mean);
         qsum = qsum + d * d;
      end
      stats.mean  = mean[MAG_W-1:0];
      stats.stdev = MAG_W'(int_sqrt(qsum / n));
      stats.total = acc_mag[TOTAL_W-1:0];
      s2 = magnitude_of(acc_x) * magnitude_of(acc_x) + magnitude_of(acc_y) * magnitude_of(acc_y)
         + magnitude_of(acc_z) * magnitude_of(acc_z) + magnitude_of(acc_w) * magnitude_of(acc_w);
      if (s2 != 0) begin
         shift = 0;
         while (shift < 30 && (s2 << 2) < (64'd1 << 62)) begin
            s2 = s2 << 2;
            shift++;
         end
         len = int_sqrt(s2);
         stats.dx = unit_component(acc_x, len, shift);
         stats.dy = unit_component(acc_y, len, shift);
         stats.dz = unit_component(acc_z, len, shift);
         stats.dw = unit_component(acc_w, len, shift);
      end
      acc_x = 0; acc_y = 0; acc_z = 0; acc_w = 0;
      acc_mag = 0;
      frame_pos = 0;
      return 1;
   endfunction

   // Mostly short pauses, a few long ones, none during a quiet stretch.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [VEL_W-1:0] pick_component(int mode);
      int r;
      case (mode)
         0: return VEL_W'($urandom);
         1: return VEL_W'($urandom_range(0, 4095) - 2048);
         2: begin
            r = $urandom_range(0, 3);
            return (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF : (r == 2) ? 16'h0000 : 16'hFFFF;
         end
         default: return VEL_W'($urandom_range(0, 12000));
      endcase
   endfunction

   task automatic check_field(string name, logic [TOTAL_W-1:0] expected, actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
         error_count++;
      end
   endtask

   task automatic send_pixel(logic [VEL_W-1:0] x, y, z, w, bit typed,
                             frame_stats_type typed_stats);
      frame_stats_type stats;
      int gap;
      @(negedge clock);
      req_valid = 1'b1;
      req_vel_x = x; req_vel_y = y; req_vel_z = z; req_vel_w = w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (take_pixel(x, y, z, w, stats)) pending_frames.push_back(typed ? typed_stats : stats);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_vel_x = VEL_W'($urandom); req_vel_y = VEL_W'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Waits until every result is in and the block has finished any pixel
   // that produces none.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_pixel_count(logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      frame_size_reg = 32'(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_random(int mode);
      send_pixel(pick_component(mode), pick_component(mode), pick_component(mode),
                 pick_component(mode), 1'b0, '0);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side: random stalls, one long hold on request, and checking.
   initial begin
      int stall_left;
      int hold_left;
      bit hold_done;
      frame_stats_type expected;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_stall  = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 299) == 0) quiet = ~quiet;
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (pending_frames.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual mean %0d", $time,
                        rsp_mean_magnitude);
               error_count++;
            end else begin
               expected = pending_frames.pop_front();
               check_field("mean_magnitude", TOTAL_W'(expected.mean),
                           TOTAL_W'(rsp_mean_magnitude));
               check_field("stdev_magnitude", TOTAL_W'(expected.stdev),
                           TOTAL_W'(rsp_stdev_magnitude));
               check_field("total_magnitude", expected.total, rsp_total_magnitude);
               check_field("dir_x", TOTAL_W'(expected.dx), TOTAL_W'({rsp_dir_x}));
               check_field("dir_y", TOTAL_W'(expected.dy), TOTAL_W'({rsp_dir_y}));
               check_field("dir_z", TOTAL_W'(expected.dz), TOTAL_W'({rsp_dir_z}));
               check_field("dir_w", TOTAL_W'(expected.dw), TOTAL_W'({rsp_dir_w}));
            end
         end
      end
   end

   initial begin
      frame_stats_type typed_stats;
      int sent, size, taken, mode;
      reset = 1'b1;
      req_valid = 1'b0;
      req_vel_x = '0; req_vel_y = '0; req_vel_z = '0; req_vel_w = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      acc_x = 0; acc_y = 0; acc_z = 0; acc_w = 0;
      acc_mag = 0;
      frame_pos = 0;
      frame_size_reg = CFG_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CONFIG) begin
            settle();
            write_pixel_count(CFG_W'(stim_rows[i].vx));
         end else begin
            typed_stats = '{MAG_W'(stim_rows[i].mean), MAG_W'(stim_rows[i].stdev),
                            TOTAL_W'(stim_rows[i].total),
                            DIR_W'(stim_rows[i].dx), DIR_W'(stim_rows[i].dy),
                            DIR_W'(stim_rows[i].dz), DIR_W'(stim_rows[i].dw)};
            send_pixel(VEL_W'(stim_rows[i].vx), VEL_W'(stim_rows[i].vy),
                       VEL_W'(stim_rows[i].vz), VEL_W'(stim_rows[i].vw),
                       stim_rows[i].typed, typed_stats);
         end
      end

      // One frame per pixel while the result side holds off for a long time.
      settle();
      write_pixel_count(CFG_W'(1));
      hold_request = 1'b1;
      for (int i = 0; i < 12; i++) send_random(0);
      sent = 12;

      while (sent < RANDOM_ITEMS) begin
         settle();
         mode = $urandom_range(0, 3);
         case ($urandom_range(0, 99)) inside
            [0:69]:  size = $urandom_range(1, 12);
            [70:87]: size = $urandom_range(13, 40);
            [88:96]: size = $urandom_range(41, 150);
            default: size = $urandom_range(300, 600);
         endcase
         if (size > RANDOM_ITEMS - sent) size = RANDOM_ITEMS - sent;
         write_pixel_count(CFG_W'(size));
         if (size > 1 && $urandom_range(0, 99) < 8) begin
            // Lower the pixel count to at most what the frame has already taken.
            taken = $urandom_range(1, size - 1);
            for (int i = 0; i < taken; i++) send_random(mode);
            settle();
            write_pixel_count(CFG_W'($urandom_range(1, taken)));
            send_random(mode);
            sent += taken + 1;
         end else begin
            for (int i = 0; i < size; i++) send_random(mode);
            sent += size;
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (error_count == 0 && pending_frames.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
